/* hdl/sle_pkg.sv */
// Shared types and constants for the sorted list engine.
// Used by sle_cell and sorted_list_engine_top; no dependencies.
package sle_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic signed [DATA_W-1:0] data_t;

	localparam logic [1:0] OP_INS  = 2'd0;
	localparam logic [1:0] OP_DEL  = 2'd1;
	localparam logic [1:0] OP_DUMP = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INS,
		CMD_DEL,
		CMD_ROT
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t code;
		data_t     key;
	} cell_cmd_t;

	typedef struct packed {
		data_t entry;
		logic  valid;
		logic  gt;
		logic  found;
		logic  is_top;
	} cell_out_t;

endpackage

/* hdl/sle_cell.sv */
// One cell of the sorted chain: holds one entry and its valid bit.
// Depends on sle_pkg.
module sle_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sle_pkg::cell_cmd_t cmd,
	input  sle_pkg::cell_out_t left,
	input  sle_pkg::cell_out_t right,
	output sle_pkg::cell_out_t cout
);
	import sle_pkg::*;

	data_t entry_q;
	logic  valid_q;
	logic  gt;
	logic  del_here;

	assign gt       = valid_q && (cmd.key > entry_q);
	assign del_here = left.found || (valid_q && (entry_q == cmd.key));

	always_comb begin
		cout.entry  = entry_q;
		cout.valid  = valid_q;
		cout.gt     = gt;
		cout.found  = del_here;
		cout.is_top = valid_q && !right.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.code)
				CMD_INS: if (!gt) valid_q <= left.valid;
				CMD_DEL: if (del_here) valid_q <= right.valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_INS: begin
				if (!gt) entry_q <= left.gt ? cmd.key : left.entry;
			end
			CMD_DEL: begin
				if (del_here) entry_q <= right.entry;
			end
			CMD_ROT: begin
				if (valid_q) entry_q <= left.entry;
			end
			default: entry_q <= entry_q;
		endcase
	end

endmodule

/* hdl/sorted_list_engine_top.sv */
// Sorted list engine: insert, delete first match, descending dump.
// Latency: insert and delete give their one result word in the cycle after acceptance.
// Dump of n entries: acceptance enters the dump state, which registers the first word;
// then one word per cycle for n words while not stalled, from the highest valid cell.
// Throughput: one word per cycle out unless stalled; a new op waits for the dump to end.
// Reset clears the fill count and every cell's valid bit; cell contents are not cleared.
// Depends on sle_pkg and sle_cell.
module sorted_list_engine_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           op,
	input  sle_pkg::data_t       key,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output sle_pkg::data_t       out_value,
	output logic                 last
);
	import sle_pkg::*;

	typedef enum logic {S_IDLE, S_DUMP} state_t;

	state_t    state_q;
	cnt_t      cnt_q;
	cnt_t      remain_q;
	logic      out_valid_q;
	logic [1:0] status_q;
	data_t     value_q;
	logic      last_q;

	cell_cmd_t cmd;
	cell_out_t cells [DEPTH];
	cell_out_t lefts [DEPTH];
	cell_out_t rights[DEPTH];
	cell_out_t edge_l;
	cell_out_t edge_r;
	data_t     top_value;
	logic [DEPTH-1:0] valid_vec;

	logic out_free;
	logic accept;
	logic full;
	logic empty;
	logic found;
	logic word_set;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign full     = (cnt_q == cnt_t'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign found    = cells[DEPTH-1].found;
	assign word_set = (state_q == S_IDLE)
		? (accept && (op == OP_INS || op == OP_DEL || (op == OP_DUMP && empty)))
		: out_free;

	always_comb begin
		top_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (cells[i].is_top) top_value = top_value | cells[i].entry;
			valid_vec[i] = cells[i].valid;
		end
	end

	always_comb begin
		edge_l = '{entry: top_value, valid: 1'b1, gt: 1'b1, found: 1'b0, is_top: 1'b0};
		edge_r = '{entry: '0, valid: 1'b0, gt: 1'b0, found: 1'b0, is_top: 1'b0};
	end

	always_comb begin
		cmd.key  = key;
		cmd.code = CMD_HOLD;
		if (accept && op == OP_INS && !full) cmd.code = CMD_INS;
		else if (accept && op == OP_DEL && !empty) cmd.code = CMD_DEL;
		else if (state_q == S_DUMP && out_free) cmd.code = CMD_ROT;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_l0
			assign lefts[i] = edge_l;
		end else begin : g_ln
			assign lefts[i] = cells[i-1];
		end
		if (i == DEPTH - 1) begin : g_rn
			assign rights[i] = edge_r;
		end else begin : g_r
			assign rights[i] = cells[i+1];
		end
		sle_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.left  (lefts[i]),
			.right (rights[i]),
			.cout  (cells[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			value_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (word_set) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						value_q <= '0;
						last_q  <= 1'b1;
						case (op)
							OP_INS: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									cnt_q    <= cnt_q + cnt_t'(1);
								end
							end
							OP_DEL: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else if (found) begin
									status_q <= ST_OK;
									cnt_q    <= cnt_q - cnt_t'(1);
								end else begin
									status_q <= ST_NOTFOUND;
								end
							end
							OP_DUMP: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									state_q  <= S_DUMP;
									remain_q <= cnt_q;
								end
							end
							default: ;
						endcase
					end
				end
				S_DUMP: begin
					if (out_free) begin
						status_q    <= ST_OK;
						value_q     <= top_value;
						last_q      <= (remain_q == cnt_t'(1));
						remain_q    <= remain_q - cnt_t'(1);
						if (remain_q == cnt_t'(1)) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_value = value_q;
	assign last      = last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnt_t'(DEPTH)) else $error("fill count beyond depth");
	a_cnt_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(cnt_q)) else $error("valid bits disagree with count");
	a_dump_remain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DUMP |-> (remain_q != '0 && remain_q <= cnt_q))
		else $error("dump counter out of range");
	a_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(valid_vec & ~(valid_vec << 1)) && valid_vec[0] == !empty)
		else $error("valid bits not contiguous");

endmodule

/* bench/tb_sorted_list_engine_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for sorted_list_engine_top: insert, delete and dump words
// are checked against an in-bench model of the sorted table. Depends on sle_pkg.
module tb_sorted_list_engine_top;
	import sle_pkg::*;

	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0] op_code;
		data_t      key_val;
	} list_req_t;

	typedef struct packed {
		logic [1:0] status;
		data_t      value;
		logic       last;
	} list_word_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [1:0] op        = OP_INS;
	data_t      key       = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] status;
	data_t      out_value;
	logic       last;

	list_req_t  pending_ops[$];
	list_word_t expected_words[$];
	data_t      list_vals[DEPTH];
	int         list_len = 0;

	bit         failed    = 1'b0;
	bit         in_taken  = 1'b0;
	int         words_in  = 0;
	int         gap_left  = 0;
	int         burst_left = 8;
	int         hold_left = 0;
	bit         hold_done = 1'b0;
	int         rx_mode   = 0;
	int         rx_left   = 40;
	int         idle_cycles = 0;
	list_req_t  next_req;
	list_word_t got_word;
	list_word_t exp_word;

	sorted_list_engine_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.key       (key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_value (out_value),
		.last      (last)
	);

	always #2 clk = ~clk;

	function automatic void queue_op(logic [1:0] o, data_t k);
		list_req_t r;
		r.op_code = o;
		r.key_val = k;
		pending_ops.push_back(r);
	endfunction

	function automatic void expect_word(logic [1:0] st, data_t v, logic lst);
		list_word_t w;
		w.status = st;
		w.value  = v;
		w.last   = lst;
		expected_words.push_back(w);
	endfunction

	// updates the table copy and queues the words this op should produce
	task automatic apply_list_op(logic [1:0] opc, data_t k);
		int pos;
		int i;
		pos = 0;
		case (opc)
			OP_INS: begin
				if (list_len >= DEPTH) begin
					expect_word(ST_FULL, '0, 1'b1);
				end else begin
					while (pos < list_len && k > list_vals[pos])
						pos++;
					for (i = list_len; i > pos; i--)
						list_vals[i] = list_vals[i-1];
					list_vals[pos] = k;
					list_len++;
					expect_word(ST_OK, '0, 1'b1);
				end
			end
			OP_DEL: begin
				if (list_len == 0) begin
					expect_word(ST_EMPTY, '0, 1'b1);
				end else begin
					while (pos < list_len && list_vals[pos] != k)
						pos++;
					if (pos == list_len) begin
						expect_word(ST_NOTFOUND, '0, 1'b1);
					end else begin
						for (i = pos; i + 1 < list_len; i++)
							list_vals[i] = list_vals[i+1];
						list_len--;
						expect_word(ST_OK, '0, 1'b1);
					end
				end
			end
			OP_DUMP: begin
				if (list_len == 0) begin
					expect_word(ST_EMPTY, '0, 1'b1);
				end else begin
					for (i = list_len - 1; i >= 0; i--)
						expect_word(ST_OK, list_vals[i], i == 0);
				end
			end
			default: ;
		endcase
	endtask

	// input side: acceptance and prediction
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			apply_list_op(op, key);
			in_taken = 1'b1;
			words_in++;
		end
	end

	// driver: bursts with random gaps
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (pending_ops.size() > 0) begin
				next_req = pending_ops.pop_front();
				in_valid <= 1'b1;
				op       <= next_req.op_code;
				key      <= next_req.key_val;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: one long hold-off, otherwise changing stall patterns
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!hold_done && words_in >= 60) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					rx_left = $urandom_range(32, 100);
				end else begin
					rx_left--;
				end
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 1) == 1);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_word.status = status;
			got_word.value  = out_value;
			got_word.last   = last;
			if (expected_words.size() == 0) begin
				$error("unexpected word: status %0d out_value %0d last %0b",
					status, out_value, last);
				failed = 1'b1;
			end else begin
				exp_word = expected_words.pop_front();
				if (got_word.status !== exp_word.status) begin
					$error("status: expected %0d, got %0d", exp_word.status, got_word.status);
					failed = 1'b1;
				end
				if (got_word.value !== exp_word.value) begin
					$error("out_value: expected %0d, got %0d", exp_word.value, got_word.value);
					failed = 1'b1;
				end
				if (got_word.last !== exp_word.last) begin
					$error("last: expected %0b, got %0b", exp_word.last, got_word.last);
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("sorted_list_engine_top: mismatch");
				$finish;
			end
		end
	end

	initial begin : stimulus
		data_t key_pool[12];
		int    i;
		int    n_gen;
		int    phase_len;
		int    r;
		bit    fill_phase;
		data_t k;

		// directed: empty cases, extremes, duplicates, sole entry, full table
		queue_op(OP_DUMP, '0);
		queue_op(OP_DEL, 32'sd3);
		queue_op(OP_INS, 32'sd5);
		queue_op(OP_DEL, 32'sd5);
		queue_op(OP_INS, 32'sh8000_0000);
		queue_op(OP_INS, 32'sh7fff_ffff);
		queue_op(OP_INS, '0);
		queue_op(OP_INS, '0);
		queue_op(OP_DUMP, 32'sh7fff_ffff);
		queue_op(OP_DEL, 32'sd7);
		queue_op(OP_DEL, '0);
		for (i = 0; i < 14; i++)
			queue_op(OP_INS, (i % 3 == 0) ? -32'sd1 : data_t'($urandom));
		queue_op(OP_DUMP, '0);

		key_pool[0] = 32'sh8000_0000;
		key_pool[1] = 32'sh7fff_ffff;
		key_pool[2] = '0;
		key_pool[3] = -32'sd1;
		key_pool[4] = 32'sd1;
		for (i = 5; i < 12; i++)
			key_pool[i] = data_t'($urandom);

		// random: alternating fill and drain phases, keys mostly from a small pool
		n_gen = 0;
		fill_phase = 1'b0;
		while (n_gen < 445) begin
			fill_phase = !fill_phase;
			phase_len = $urandom_range(10, 60);
			for (i = 0; i < phase_len && n_gen < 445; i++) begin
				r = $urandom_range(0, 99);
				k = ($urandom_range(0, 3) == 0) ? data_t'($urandom)
					: key_pool[$urandom_range(0, 11)];
				if (r < (fill_phase ? 62 : 26))
					queue_op(OP_INS, k);
				else if (r < 88)
					queue_op(OP_DEL, k);
				else
					queue_op(OP_DUMP, k);
				n_gen++;
			end
		end

		repeat (5) @(posedge clk);
		#1 arst_n = 1'b1;

		while (pending_ops.size() > 0 || in_valid)
			@(negedge clk);
		while (expected_words.size() > 0)
			@(negedge clk);
		repeat (DEPTH + 8) @(negedge clk);

		if (!failed && expected_words.size() == 0) begin
			$display("sorted_list_engine_top: match");
		end else begin
			$display("sorted_list_engine_top: mismatch");
		end
		$finish;
	end

endmodule
